>>> src/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define GCD_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("gcd assertion failed");

// property whose consequent must hold in the cycle after the antecedent
`define GCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gcd assertion failed");

`endif

>>> src/gcd_pkg.sv
// shared types, constants and the cordic angle table for the distance block
`timescale 1ns / 1ps
package gcd_pkg;

	// cordic datapath width and product width
	localparam int CW = 34;
	localparam int PW = 2 * CW;
	localparam int MAX_STEPS = 32;
	localparam int SQRT_STEPS = 31;
	localparam int QUEUE_DEPTH = 4;
	localparam int QW = 2;

	// round(2^48 / 360), degrees q16 to phase word
	localparam logic [39:0] DEG_TO_PHASE = 40'd781874935307;
	// inverse cordic gain in q30
	localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
	// round(3959 * 2 * pi * 2^16)
	localparam logic [30:0] DIST_SCALE = 31'd1630216561;

	// phase words of one point pair
	typedef struct packed {
		logic [31:0] lat_a;
		logic [31:0] lon_a;
		logic [31:0] lat_b;
		logic [31:0] lon_b;
	} gcd_phase_t;

	// arctangent of 2^-i as a phase word
	function automatic logic [31:0] atan_phase(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0: a = 32'd536870912;
			5'd1: a = 32'd316933406;
			5'd2: a = 32'd167458907;
			5'd3: a = 32'd85004756;
			5'd4: a = 32'd42667331;
			5'd5: a = 32'd21354465;
			5'd6: a = 32'd10679838;
			5'd7: a = 32'd5340245;
			5'd8: a = 32'd2670163;
			5'd9: a = 32'd1335087;
			5'd10: a = 32'd667544;
			5'd11: a = 32'd333772;
			5'd12: a = 32'd166886;
			5'd13: a = 32'd83443;
			5'd14: a = 32'd41722;
			5'd15: a = 32'd20861;
			5'd16: a = 32'd10430;
			5'd17: a = 32'd5215;
			5'd18: a = 32'd2608;
			5'd19: a = 32'd1304;
			5'd20: a = 32'd652;
			5'd21: a = 32'd326;
			5'd22: a = 32'd163;
			5'd23: a = 32'd81;
			5'd24: a = 32'd41;
			5'd25: a = 32'd20;
			5'd26: a = 32'd10;
			5'd27: a = 32'd5;
			5'd28: a = 32'd3;
			5'd29: a = 32'd1;
			5'd30: a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

>>> src/gcd_in_if.sv
// input channel: one point pair per beat
`timescale 1ns / 1ps
interface gcd_in_if;
	logic valid;
	logic ready;
	logic signed [23:0] first_latitude;
	logic signed [24:0] first_longitude;
	logic signed [23:0] second_latitude;
	logic signed [24:0] second_longitude;

	modport source(output valid, first_latitude, first_longitude, second_latitude,
		second_longitude, input ready);
	modport sink(input valid, first_latitude, first_longitude, second_latitude,
		second_longitude, output ready);
endinterface

>>> src/gcd_out_if.sv
// output channel: one distance per beat
`timescale 1ns / 1ps
interface gcd_out_if;
	logic valid;
	logic ready;
	logic [21:0] distance_miles;

	modport source(output valid, distance_miles, input ready);
	modport sink(input valid, distance_miles, output ready);
endinterface

>>> src/gcd_front.sv
// front end: takes point pairs and turns degrees into phase words
`timescale 1ns / 1ps
module gcd_front import gcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gcd_in_if.sink     points,
	output logic       push,
	output gcd_phase_t push_data,
	input  logic       full
);

	// partial product of a coordinate with one 20-bit half of the scale
	function automatic logic signed [45:0] mul_part(input logic signed [24:0] deg,
		input logic [19:0] k);
		return deg * $signed({1'b0, k});
	endfunction

	// recombine halves, round, keep the top word
	function automatic logic [31:0] to_phase(input logic signed [45:0] hi,
		input logic signed [45:0] lo);
		logic signed [63:0] sum;
		sum = (64'(hi) <<< 20) + 64'(lo) + 64'sd2147483648;
		return sum[63:32];
	endfunction

	logic [1:0] vld_s;
	logic en;
	logic signed [24:0] deg [4];
	logic signed [45:0] hi_s1 [4];
	logic signed [45:0] lo_s1 [4];
	logic [31:0] ph_s2 [4];

	// stage moves unless the last beat cannot go into the queue
	assign en = !vld_s[1] || !full;
	assign points.ready = en;
	assign push = vld_s[1] && !full;

	// coordinates at a common width
	always_comb begin
		deg[0] = 25'(points.first_latitude);
		deg[1] = points.first_longitude;
		deg[2] = 25'(points.second_latitude);
		deg[3] = points.second_longitude;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[0], points.valid};
		end
	end

	// scale multiply in two halves, then sum
	for (genvar c = 0; c < 4; c++) begin : g_coord
		always_ff @(posedge clk) begin
			if (en) begin
				hi_s1[c] <= mul_part(deg[c], DEG_TO_PHASE[39:20]);
				lo_s1[c] <= mul_part(deg[c], DEG_TO_PHASE[19:0]);
				ph_s2[c] <= to_phase(hi_s1[c], lo_s1[c]);
			end
		end
	end

	assign push_data = '{lat_a: ph_s2[0], lon_a: ph_s2[1], lat_b: ph_s2[2], lon_b: ph_s2[3]};

endmodule

>>> src/gcd_fifo.sv
// short queue between front and back end
`timescale 1ns / 1ps
module gcd_fifo import gcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  gcd_phase_t push_data,
	output logic       full,
	input  logic       pop,
	output gcd_phase_t pop_data,
	output logic       empty
);

	logic [QW-1:0] wr_q;
	logic [QW-1:0] rd_q;
	logic [QW:0] cnt_q;
	gcd_phase_t mem_q [QUEUE_DEPTH];

	assign full = cnt_q == (QW+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule

>>> src/gcd_sincos.sv
// pipelined rotation cordic: phase word to cosine and sine in q30
`timescale 1ns / 1ps
module gcd_sincos import gcd_pkg::*; #(
	parameter int STEPS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic [31:0]          phase,
	output logic                 out_v,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o
);

	logic [STEPS+1:0] vld_s;
	logic [1:0] quad_c;
	logic [31:0] r_c;
	logic [1:0] quad_s [0:STEPS];
	logic signed [CW-1:0] x_s [0:STEPS];
	logic signed [CW-1:0] y_s [0:STEPS];
	logic signed [CW-1:0] z_s [0:STEPS];

	// quadrant and residual angle
	always_comb begin
		quad_c = 2'((phase + 32'h2000_0000) >> 30);
		r_c = phase - {quad_c, 30'b0};
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[STEPS:0], in_v};
		end
	end
	assign out_v = vld_s[STEPS+1];

	// start vector
	always_ff @(posedge clk) begin
		if (en) begin
			quad_s[0] <= quad_c;
			x_s[0] <= GAIN_INV;
			y_s[0] <= '0;
			z_s[0] <= CW'($signed(r_c));
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < STEPS; k++) begin : g_iter
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] da;
		assign dx = y_s[k] >>> k;
		assign dy = x_s[k] >>> k;
		assign da = $signed({2'b0, atan_phase(5'(k))});
		always_ff @(posedge clk) begin
			if (en) begin
				quad_s[k+1] <= quad_s[k];
				if (!z_s[k][CW-1]) begin
					x_s[k+1] <= x_s[k] - dx;
					y_s[k+1] <= y_s[k] + dy;
					z_s[k+1] <= z_s[k] - da;
				end else begin
					x_s[k+1] <= x_s[k] + dx;
					y_s[k+1] <= y_s[k] - dy;
					z_s[k+1] <= z_s[k] + da;
				end
			end
		end
	end

	// rotate back by the quadrant
	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s[STEPS])
				2'd0: begin
					cos_o <= x_s[STEPS];
					sin_o <= y_s[STEPS];
				end
				2'd1: begin
					cos_o <= -y_s[STEPS];
					sin_o <= x_s[STEPS];
				end
				2'd2: begin
					cos_o <= -x_s[STEPS];
					sin_o <= -y_s[STEPS];
				end
				default: begin
					cos_o <= y_s[STEPS];
					sin_o <= -x_s[STEPS];
				end
			endcase
		end
	end

endmodule

>>> src/gcd_back.sv
// back end: unit vectors, dot product, square root, arc cosine and scaling
`timescale 1ns / 1ps
module gcd_back import gcd_pkg::*; #(
	parameter int STEPS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  gcd_phase_t q_data,
	output logic       q_take,
	gcd_out_if.source  result
);

	logic en;
	logic [31:0] ph [4];
	logic [3:0] sc_v;
	logic signed [CW-1:0] sc_cos [4];
	logic signed [CW-1:0] sc_sin [4];

	// vector and dot stages
	logic [5:0] vld_s;
	logic signed [PW-1:0] m0_s1 [2];
	logic signed [PW-1:0] m1_s1 [2];
	logic signed [CW-1:0] sp_s1 [2];
	logic signed [CW-1:0] va_s2 [2][3];
	logic signed [PW-1:0] c_s3 [3];
	logic signed [PW:0] s01_s4;
	logic signed [PW-1:0] c2_s4;
	logic signed [PW+1:0] dot_c;
	logic signed [31:0] d_s5;
	logic signed [31:0] d_s6;
	logic [63:0] dd_s6;

	// square root stages
	logic [SQRT_STEPS:0] sq_v;
	logic [61:0] rem_s [0:SQRT_STEPS];
	logic [61:0] res_s [0:SQRT_STEPS];
	logic signed [31:0] sd_s [0:SQRT_STEPS];

	// arc cosine stages
	logic [STEPS:0] ac_v;
	logic signed [CW-1:0] ad_c;
	logic signed [CW-1:0] as_c;
	logic signed [CW-1:0] ax_s [0:STEPS];
	logic signed [CW-1:0] ay_s [0:STEPS];
	logic signed [CW-1:0] az_s [0:STEPS];

	// clamp, scale and output
	logic zc_v_q;
	logic [31:0] zc_q;
	logic pr_v_q;
	logic [62:0] prod_q;
	logic [63:0] dist_c;
	logic out_v_q;
	logic [21:0] out_q;

	// the whole chain moves while the output register is free or taken
	assign en = !out_v_q || result.ready;
	assign q_take = en && q_valid;
	assign result.valid = out_v_q;
	assign result.distance_miles = out_q;

	assign ph[0] = q_data.lat_a;
	assign ph[1] = q_data.lon_a;
	assign ph[2] = q_data.lat_b;
	assign ph[3] = q_data.lon_b;

	// sine and cosine of all four angles
	for (genvar a = 0; a < 4; a++) begin : g_sc
		gcd_sincos #(.STEPS(STEPS)) u_sc (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.in_v  (q_take),
			.phase (ph[a]),
			.out_v (sc_v[a]),
			.cos_o (sc_cos[a]),
			.sin_o (sc_sin[a])
		);
	end

	// valid chain of the vector and dot stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], sc_v[0]};
		end
	end

	// unit vectors of both points
	for (genvar p = 0; p < 2; p++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				m0_s1[p] <= PW'(sc_cos[2*p+1]) * PW'(sc_cos[2*p]);
				m1_s1[p] <= PW'(sc_sin[2*p+1]) * PW'(sc_cos[2*p]);
				sp_s1[p] <= sc_sin[2*p];
				va_s2[p][0] <= CW'((m0_s1[p] + PW'(64'sd536870912)) >>> 30);
				va_s2[p][1] <= CW'((m1_s1[p] + PW'(64'sd536870912)) >>> 30);
				va_s2[p][2] <= sp_s1[p];
			end
		end
	end

	// dot product, rounded and clamped to one
	always_comb begin
		dot_c = ((PW+2)'(s01_s4) + (PW+2)'(c2_s4) + (PW+2)'(64'sd536870912)) >>> 30;
	end

	for (genvar i = 0; i < 3; i++) begin : g_dot
		always_ff @(posedge clk) begin
			if (en) c_s3[i] <= va_s2[0][i] * va_s2[1][i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s01_s4 <= (PW+1)'(c_s3[0]) + (PW+1)'(c_s3[1]);
			c2_s4 <= c_s3[2];
			if (dot_c > (PW+2)'(64'sd1073741824)) d_s5 <= 32'sd1073741824;
			else if (dot_c < -(PW+2)'(64'sd1073741824)) d_s5 <= -32'sd1073741824;
			else d_s5 <= 32'(dot_c);
			dd_s6 <= 64'(d_s5) * 64'(d_s5);
			d_s6 <= d_s5;
		end
	end

	// square root of one minus dot squared, one result bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v <= '0;
		end else if (en) begin
			sq_v <= {sq_v[SQRT_STEPS-1:0], vld_s[5]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (62'd1 << 60) - 62'(dd_s6);
			res_s[0] <= '0;
			sd_s[0] <= d_s6;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
		logic [61:0] trial;
		assign trial = res_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[k+1] <= sd_s[k];
				if (rem_s[k] >= trial) begin
					rem_s[k+1] <= rem_s[k] - trial;
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
			end
		end
	end

	// vectoring cordic for the angle, turned by a quarter for negative dot
	assign ad_c = CW'(sd_s[SQRT_STEPS]);
	assign as_c = $signed({2'b0, res_s[SQRT_STEPS][31:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac_v <= '0;
		end else if (en) begin
			ac_v <= {ac_v[STEPS-1:0], sq_v[SQRT_STEPS]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ad_c < 0) begin
				ax_s[0] <= as_c;
				ay_s[0] <= -ad_c;
				az_s[0] <= CW'(64'sd1073741824);
			end else begin
				ax_s[0] <= ad_c;
				ay_s[0] <= as_c;
				az_s[0] <= '0;
			end
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_acos
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] da;
		assign dx = ay_s[k] >>> k;
		assign dy = ax_s[k] >>> k;
		assign da = $signed({2'b0, atan_phase(5'(k))});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!ay_s[k][CW-1]) begin
					ax_s[k+1] <= ax_s[k] + dx;
					ay_s[k+1] <= ay_s[k] - dy;
					az_s[k+1] <= az_s[k] + da;
				end else begin
					ax_s[k+1] <= ax_s[k] - dx;
					ay_s[k+1] <= ay_s[k] + dy;
					az_s[k+1] <= az_s[k] - da;
				end
			end
		end
	end

	// clamp angle to half a turn, scale by earth radius, round to output
	assign dist_c = 64'(prod_q) + (64'd1 << 39);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zc_v_q <= 1'b0;
			pr_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			zc_v_q <= ac_v[STEPS];
			pr_v_q <= zc_v_q;
			out_v_q <= pr_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (az_s[STEPS] < 0) zc_q <= '0;
			else if (az_s[STEPS] > CW'(64'sd2147483648)) zc_q <= 32'h8000_0000;
			else zc_q <= 32'(az_s[STEPS]);
			prod_q <= 63'(zc_q) * 63'(DIST_SCALE);
			out_q <= dist_c[61:40];
		end
	end

endmodule

>>> src/great_circle_distance.sv
// top level of the great-circle distance block
`timescale 1ns / 1ps
// Great-circle distance by the spherical law of cosines. Each beat on points carries two
// positions as latitude and longitude in degrees with 16 fraction bits; each beat on result
// carries the distance in miles with 8 fraction bits. The block is fully pipelined and takes
// one point pair every cycle while result is not stalled; its latency is set by the four
// parallel sine/cosine cordic pipelines, the 31-stage square root and the arc cosine cordic
// pipeline, each of which retires one micro-step per stage. A four-entry queue sits between
// the degree conversion front end and the arithmetic back end, so the front end keeps taking
// beats after result stalls until the queue is full.
module great_circle_distance import gcd_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input logic    clk,
	input logic    arst_n,
	gcd_in_if.sink     points,
	gcd_out_if.source  result
);

	localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;

	logic push;
	logic full;
	logic pop;
	logic empty;
	gcd_phase_t push_data;
	gcd_phase_t pop_data;

	gcd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (points),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	gcd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	gcd_back #(.STEPS(STEPS)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(!empty),
		.q_data (pop_data),
		.q_take (pop),
		.result (result)
	);

endmodule

>>> src/gcd_checker.sv
// port-level checks on the distance block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [21:0] distance_miles
);

	logic [7:0] open_q;

	// beats taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	// every result beat belongs to an input beat
	`GCD_ASSERT(a_no_extra_result, clk, arst_n, !out_valid || open_q != 8'd0)

	// distance never exceeds half the circumference
	`GCD_ASSERT(a_dist_range, clk, arst_n, !out_valid || distance_miles <= 22'd3184100)

	// a stalled result holds
	`GCD_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(distance_miles))

endmodule

bind great_circle_distance gcd_checker u_gcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (points.valid),
	.in_ready      (points.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.distance_miles(result.distance_miles)
);

>>> tb/sv/tb.sv
// great-circle distance testbench: directed and random point pairs checked against a predictor
`timescale 1ns / 1ps
module tb;
	import gcd_pkg::*;

	// one point pair plus the sender's pacing
	typedef struct {
		logic signed [23:0] lat_a;
		logic signed [24:0] lon_a;
		logic signed [23:0] lat_b;
		logic signed [24:0] lon_b;
		int gap;
		bit drain;
	} pair_t;

	localparam int NUM_STEPS = 24;
	localparam int LATENCY = 2 * NUM_STEPS + 47;
	localparam int LAT_MAX = 5898240;
	localparam int LON_MAX = 11796480;
	localparam int HOLD_AT = 150;
	localparam int HOLD_LEN = 400;
	localparam int DRAIN_AT = 320;
	localparam longint ONE = 64'sd1073741824;

	// arctangent of 2^-i as phase words
	localparam longint ATAN[32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1, 1, 0};

	logic clk;
	logic arst_n;
	gcd_in_if pin();
	gcd_out_if pout();

	pair_t pending[$];
	logic [21:0] miles_due[$];
	int errors;
	int n_seen;
	int gap_left;
	int stall_left;

	great_circle_distance #(.CORDIC_STEPS(NUM_STEPS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.points(pin),
		.result(pout)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// degrees q16 to a 32-bit phase word
	function automatic logic [31:0] to_phase(input longint deg);
		logic [63:0] p;
		p = 64'(deg) * 64'd781874935307 + 64'h80000000;
		return p[63:32];
	endfunction

	// rotation cordic, q30 cosine and sine of a phase word
	function automatic void rotate(input logic [31:0] phase, output longint c,
			output longint s);
		logic [31:0] quad;
		logic [31:0] r;
		longint x, y, z, dx, dy;
		quad = ((phase + 32'h20000000) >> 30) & 32'd3;
		r = phase - (quad << 30);
		z = longint'(signed'(r));
		x = 652032874;
		y = 0;
		for (int i = 0; i < NUM_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endfunction

	function automatic longint round30(input longint v);
		return (v + (ONE >>> 1)) >>> 30;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 60;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return longint'(res);
	endfunction

	// point pair to distance in miles * 256
	function automatic logic [21:0] miles_between(input pair_t p);
		longint cpa, spa, cla, sla, cpb, spb, clb, slb;
		longint ax, ay, bx, by, d, x, y, z, t, dx, dy;
		logic [63:0] scaled;
		rotate(to_phase(longint'(p.lat_a)), cpa, spa);
		rotate(to_phase(longint'(p.lon_a)), cla, sla);
		rotate(to_phase(longint'(p.lat_b)), cpb, spb);
		rotate(to_phase(longint'(p.lon_b)), clb, slb);
		ax = round30(cla * cpa);
		ay = round30(sla * cpa);
		bx = round30(clb * cpb);
		by = round30(slb * cpb);
		d = round30(ax * bx + ay * by + spa * spb);
		// clamp the dot product to one
		if (d > ONE) d = ONE;
		if (d < -ONE) d = -ONE;
		// vectoring cordic for the arc cosine
		x = d;
		y = int_sqrt(ONE * ONE - d * d);
		z = 0;
		if (x < 0) begin
			t = x; x = y; y = -t; z = ONE;
		end
		for (int i = 0; i < NUM_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN[i];
			end else begin
				x -= dx; y += dy; z -= ATAN[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 2 * ONE) z = 2 * ONE;
		scaled = (64'(z) * 64'd1630216561 + (64'd1 << 39)) >> 40;
		return scaled[21:0];
	endfunction

	function automatic pair_t make_pair(input longint la, input longint oa,
			input longint lb, input longint ob);
		pair_t p;
		p.lat_a = la[23:0];
		p.lon_a = oa[24:0];
		p.lat_b = lb[23:0];
		p.lon_b = ob[24:0];
		p.gap = 0;
		p.drain = 1'b0;
		return p;
	endfunction

	function automatic longint rnd_span(input int lim);
		return longint'($urandom_range(0, 2 * lim)) - lim;
	endfunction

	// sender: one pair per beat, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin.valid <= 1'b0;
			pin.first_latitude <= '0;
			pin.first_longitude <= '0;
			pin.second_latitude <= '0;
			pin.second_longitude <= '0;
			gap_left <= 0;
		end else begin
			if (pin.valid && pin.ready) begin
				miles_due.push_back(miles_between(make_pair(pin.first_latitude,
					pin.first_longitude, pin.second_latitude, pin.second_longitude)));
			end
			if (!pin.valid || pin.ready) begin
				if (gap_left > 0) begin
					pin.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() > 0 && (!pending[0].drain ||
						(miles_due.size() == 0 && !pin.valid))) begin
					pin.valid <= 1'b1;
					pin.first_latitude <= pending[0].lat_a;
					pin.first_longitude <= pending[0].lon_a;
					pin.second_latitude <= pending[0].lat_b;
					pin.second_longitude <= pending[0].lon_b;
					gap_left <= pending[0].gap;
					void'(pending.pop_front());
				end else begin
					pin.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each beat, random stall after it, one long hold
	always @(posedge clk or negedge arst_n) begin
		int w;
		if (!arst_n) begin
			pout.ready <= 1'b0;
			stall_left <= 2;
			n_seen <= 0;
		end else if (pout.valid && pout.ready) begin
			if (miles_due.size() == 0) begin
				$display("%0t: unexpected distance_miles actual %0d", $time,
					pout.distance_miles);
				errors++;
			end else begin
				if (pout.distance_miles !== miles_due[0]) begin
					$display("%0t: distance_miles expected %0d actual %0d", $time,
						miles_due[0], pout.distance_miles);
					errors++;
				end
				void'(miles_due.pop_front());
			end
			n_seen <= n_seen + 1;
			w = ((n_seen / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
			if (n_seen == HOLD_AT) w = HOLD_LEN;
			if (w > 0) begin
				pout.ready <= 1'b0;
				stall_left <= w;
			end
		end else if (!pout.ready) begin
			if (stall_left <= 1) pout.ready <= 1'b1;
			stall_left <= stall_left - 1;
		end
	end

	// stimulus and end of run
	initial begin
		pair_t p;
		int sel;
		errors = 0;
		arst_n = 1'b0;
		// directed pairs
		pending.push_back(make_pair(0, 0, 0, 0));
		pending.push_back(make_pair(0, 0, 0, 180 * 65536));
		pending.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
		pending.push_back(make_pair(LAT_MAX, 0, LAT_MAX, LON_MAX));
		pending.push_back(make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
		pending.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
		pending.push_back(make_pair(2621440, 4915200, 2621440, 4915201));
		pending.push_back(make_pair(2621440, 4915200, -2621440, -6881280));
		pending.push_back(make_pair(2621440, 4915200, -2621441, -6881280));
		pending.push_back(make_pair(8388607, 16777215, -8388608, -16777216));
		pending.push_back(make_pair(-8388608, -16777216, -8388608, -16777216));
		pending.push_back(make_pair(8388607, -16777216, 0, 16777215));
		pending.push_back(make_pair(6000000, 12000000, -6000000, -12000000));
		pending.push_back(make_pair(1, 1, -1, -1));
		pending.push_back(make_pair(0, 0, 5898240, 0));
		pending.push_back(make_pair(2693926, -4845044, 2207744, -7741440));
		pending.push_back(make_pair(-1, -1, 0, 0));
		pending.push_back(make_pair(3000000, 100, 3000000, 100));
		foreach (pending[i]) pending[i].gap = $urandom_range(0, 9);
		// random pairs: mostly in range, some raw bit patterns, some near the poles of the
		// dot product
		for (int i = 0; i < 600; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				p = make_pair(rnd_span(LAT_MAX), rnd_span(LON_MAX), rnd_span(LAT_MAX),
					rnd_span(LON_MAX));
			end else if (sel < 8) begin
				p = make_pair($urandom(), $urandom(), $urandom(), $urandom());
			end else begin
				p = make_pair(rnd_span(LAT_MAX), rnd_span(LON_MAX), 0, 0);
				p.lat_b = p.lat_a + $signed(5'($urandom_range(0, 31))) ;
				p.lon_b = p.lon_a + $signed(5'($urandom_range(0, 31)));
				if (sel == 9) begin
					p.lat_b = -p.lat_b;
					p.lon_b = p.lon_b + 25'sd11796480;
				end
			end
			p.gap = ((i / 80) % 3 == 1 || (i > 120 && i < 260)) ? 0 : $urandom_range(0, 9);
			p.drain = (i == DRAIN_AT);
			pending.push_back(p);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && !pin.valid);
		wait (miles_due.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) begin
			$display("[great_circle_distance] OK");
		end else begin
			$display("[great_circle_distance] ERROR");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3ms;
		$display("[great_circle_distance] ERROR");
		$finish;
	end
endmodule

>>> great_circle_distance.f
+incdir+src
src/gcd_pkg.sv
src/gcd_in_if.sv
src/gcd_out_if.sv
src/gcd_front.sv
src/gcd_fifo.sv
src/gcd_sincos.sv
src/gcd_back.sv
src/great_circle_distance.sv
src/gcd_checker.sv
tb/sv/tb.sv
